// ===== sv/ffpa_pkg.sv =====
// Package for the first-fit page frame allocator: sizes, codes, FSM states,
// controller/datapath command and status structs, mask helper.
// No dependencies.
`default_nettype none

package ffpa_pkg;

  localparam int unsigned MAX_PAGES   = 16384;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned BIT_W       = $clog2(WORD_W);
  localparam int unsigned ROWS        = MAX_PAGES / WORD_W;
  localparam int unsigned ROW_W       = $clog2(ROWS);
  localparam int unsigned IDX_W       = $clog2(MAX_PAGES);
  localparam int unsigned CNT_W       = 15;
  localparam int unsigned FILL_W      = CNT_W + 1;
  localparam int unsigned BASE_W      = 40;
  localparam int unsigned ADDR_W      = 52;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 40;
  // bits of one map row examined per cycle by the run search
  localparam int unsigned CHUNK_W     = 8;
  localparam int unsigned CHUNK_SEL_W = $clog2(WORD_W / CHUNK_W);
  localparam int unsigned KSEL_W      = $clog2(CHUNK_W);

  localparam logic [CNT_W-1:0] PAGES_RST = CNT_W'(MAX_PAGES);
  localparam logic [CNT_W-1:0] FLOOR_RST = CNT_W'(8192);

  typedef enum logic [CMD_W-1:0] {
    OP_INIT       = 3'd0,
    OP_ALLOC_ONE  = 3'd1,
    OP_ALLOC_USER = 3'd2,
    OP_ALLOC_RUN  = 3'd3,
    OP_FREE       = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_FRAME   = 2'd0,
    CFG_PAGES_IN_USE = 2'd1,
    CFG_USER_FLOOR   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INIT,
    S_SCAN,
    S_RUN,
    S_MARK_RD,
    S_MARK,
    S_FREE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    load_in;
    logic    rd_first;
    logic    rd_next;
    logic    init_wr;
    logic    scan_eval;
    logic    run_eval;
    logic    mark_first;
    logic    mark_eval;
    logic    free_wr;
    logic    res_set;
    status_e res_status;
    logic    res_hit;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic init_bad;
    logic alloc_empty;
    logic run_bad;
    logic free_bad;
    logic init_last;
    logic scan_hit;
    logic scan_last;
    logic run_found;
    logic run_stop;
    logic chunk_last;
    logic mark_last;
    logic out_free;
  } ctrl_sts_t;

  // Ones from bit lo up to bit hi inclusive.
  function automatic logic [WORD_W-1:0] range_mask(input logic [BIT_W-1:0] lo,
                                                   input logic [BIT_W-1:0] hi);
    logic [BIT_W-1:0] top_gap;
    top_gap = BIT_W'(WORD_W - 1) - hi;
    return ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> top_gap);
  endfunction

endpackage

`default_nettype wire

// ===== sv/ffpa_if.sv =====
// Handshake channels of the page frame allocator: request, result and
// configuration write. Depends on ffpa_pkg.
`default_nettype none

interface ffpa_in_if;
  logic                            valid;
  logic                            ready;
  logic [ffpa_pkg::CMD_W-1:0]      cmd;
  logic [ffpa_pkg::CNT_W-1:0]      run_length;
  logic [ffpa_pkg::ADDR_W-1:0]     phys_address;
  modport source (output valid, cmd, run_length, phys_address, input ready);
  modport sink   (input valid, cmd, run_length, phys_address, output ready);
endinterface

interface ffpa_out_if;
  logic                            valid;
  logic                            ready;
  logic [ffpa_pkg::ADDR_W-1:0]     page_address;
  logic [ffpa_pkg::STATUS_W-1:0]   status;
  modport source (output valid, page_address, status, input ready);
  modport sink   (input valid, page_address, status, output ready);
endinterface

interface ffpa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ffpa_pkg::CFG_IDX_W-1:0]  index;
  logic [ffpa_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/ffpa_ctrl.sv =====
// Sequencer of the page frame allocator: walks each command through its
// map sweep and drives the datapath. Depends on ffpa_pkg.
`default_nettype none

module ffpa_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ffpa_pkg::ctrl_sts_t sts_i,
  output ffpa_pkg::ctrl_cmd_t      cmd_o
);

  ffpa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffpa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffpa_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ffpa_pkg::S_DISPATCH;
      end
      ffpa_pkg::S_DISPATCH: begin
        unique case (sts_i.op) inside
          ffpa_pkg::OP_INIT: begin
            state_d = sts_i.init_bad ? ffpa_pkg::S_DONE : ffpa_pkg::S_INIT;
          end
          ffpa_pkg::OP_ALLOC_ONE, ffpa_pkg::OP_ALLOC_USER: begin
            state_d = sts_i.alloc_empty ? ffpa_pkg::S_DONE : ffpa_pkg::S_SCAN;
          end
          ffpa_pkg::OP_ALLOC_RUN: begin
            state_d = sts_i.run_bad ? ffpa_pkg::S_DONE : ffpa_pkg::S_RUN;
          end
          ffpa_pkg::OP_FREE: begin
            state_d = sts_i.free_bad ? ffpa_pkg::S_DONE : ffpa_pkg::S_FREE;
          end
          default: state_d = ffpa_pkg::S_DONE;
        endcase
      end
      ffpa_pkg::S_INIT: begin
        if (sts_i.init_last) state_d = ffpa_pkg::S_DONE;
      end
      ffpa_pkg::S_SCAN: begin
        if (sts_i.scan_hit || sts_i.scan_last) state_d = ffpa_pkg::S_DONE;
      end
      ffpa_pkg::S_RUN: begin
        if (sts_i.run_found) begin
          state_d = ffpa_pkg::S_MARK_RD;
        end else if (sts_i.run_stop) begin
          state_d = ffpa_pkg::S_DONE;
        end
      end
      ffpa_pkg::S_MARK_RD: state_d = ffpa_pkg::S_MARK;
      ffpa_pkg::S_MARK: begin
        if (sts_i.mark_last) state_d = ffpa_pkg::S_DONE;
      end
      ffpa_pkg::S_FREE: state_d = ffpa_pkg::S_DONE;
      ffpa_pkg::S_DONE: begin
        if (sts_i.out_free) state_d = ffpa_pkg::S_IDLE;
      end
      default: state_d = ffpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = ffpa_pkg::ST_OK;
    in_ready_o       = 1'b0;
    unique case (state_q)
      ffpa_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ffpa_pkg::S_DISPATCH: begin
        unique case (sts_i.op) inside
          ffpa_pkg::OP_INIT: begin
            if (sts_i.init_bad) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ffpa_pkg::ST_BAD;
            end
          end
          ffpa_pkg::OP_ALLOC_ONE, ffpa_pkg::OP_ALLOC_USER: begin
            if (sts_i.alloc_empty) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ffpa_pkg::ST_NONE;
            end else begin
              cmd_o.rd_first = 1'b1;
            end
          end
          ffpa_pkg::OP_ALLOC_RUN: begin
            if (sts_i.run_bad) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ffpa_pkg::ST_NONE;
            end else begin
              cmd_o.rd_first = 1'b1;
            end
          end
          ffpa_pkg::OP_FREE: begin
            if (sts_i.free_bad) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ffpa_pkg::ST_BAD;
            end else begin
              cmd_o.rd_first = 1'b1;
            end
          end
          default: begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ffpa_pkg::ST_OK;
          end
        endcase
      end
      ffpa_pkg::S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ffpa_pkg::ST_OK;
        end
      end
      ffpa_pkg::S_SCAN: begin
        cmd_o.scan_eval = 1'b1;
        cmd_o.rd_next   = 1'b1;
        if (sts_i.scan_hit) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ffpa_pkg::ST_OK;
          cmd_o.res_hit    = 1'b1;
        end else if (sts_i.scan_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ffpa_pkg::ST_NONE;
        end
      end
      ffpa_pkg::S_RUN: begin
        cmd_o.run_eval = 1'b1;
        // fetch the next row while the last chunk of this one is examined
        cmd_o.rd_next  = sts_i.chunk_last && !sts_i.run_found && !sts_i.run_stop;
        if (!sts_i.run_found && sts_i.run_stop) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ffpa_pkg::ST_NONE;
        end
      end
      ffpa_pkg::S_MARK_RD: cmd_o.mark_first = 1'b1;
      ffpa_pkg::S_MARK: begin
        cmd_o.mark_eval = 1'b1;
        if (sts_i.mark_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ffpa_pkg::ST_OK;
          cmd_o.res_hit    = 1'b1;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      ffpa_pkg::S_FREE: begin
        cmd_o.free_wr    = 1'b1;
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = ffpa_pkg::ST_OK;
      end
      ffpa_pkg::S_DONE: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ffpa_dp.sv =====
// Datapath of the page frame allocator: configuration registers, occupied
// map memory with row valid flags, search logic and result registers.
// Depends on ffpa_pkg.
`default_nettype none

module ffpa_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [ffpa_pkg::CMD_W-1:0]        in_cmd_i,
  input  wire logic [ffpa_pkg::CNT_W-1:0]        in_run_length_i,
  input  wire logic [ffpa_pkg::ADDR_W-1:0]       in_phys_address_i,
  input  wire logic                              cfg_valid_i,
  input  wire logic [ffpa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ffpa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire ffpa_pkg::ctrl_cmd_t               cmd_i,
  output ffpa_pkg::ctrl_sts_t                    sts_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [ffpa_pkg::ADDR_W-1:0]            out_page_address_o,
  output logic [ffpa_pkg::STATUS_W-1:0]          out_status_o
);

  // configuration
  logic [ffpa_pkg::BASE_W-1:0] base_q;
  logic [ffpa_pkg::CNT_W-1:0]  pages_q;
  logic [ffpa_pkg::CNT_W-1:0]  floor_q;

  // latched request word
  ffpa_pkg::op_e               op_q;
  logic [ffpa_pkg::CNT_W-1:0]  len_q;
  logic [ffpa_pkg::BASE_W-1:0] frame_q;

  // map memory
  logic [ffpa_pkg::WORD_W-1:0] mem_q [ffpa_pkg::ROWS];
  logic [ffpa_pkg::ROWS-1:0]   row_valid_q;
  logic [ffpa_pkg::WORD_W-1:0] rdata_q;
  logic                        rvalid_q;
  logic [ffpa_pkg::ROW_W-1:0]  eval_row_q, eval_row_d;
  logic [ffpa_pkg::ROW_W-1:0]  ptr_q, ptr_d;

  // search state
  logic [ffpa_pkg::CNT_W-1:0]       run_q;
  logic [ffpa_pkg::CHUNK_SEL_W-1:0] chunk_q;
  logic [ffpa_pkg::IDX_W-1:0]       hit_idx_q;
  logic [ffpa_pkg::IDX_W-1:0]       end_idx_q;

  // result
  ffpa_pkg::status_e           res_status_q;
  logic                        res_hit_q;
  logic                        out_valid_q;
  logic [ffpa_pkg::ADDR_W-1:0] out_addr_q;
  ffpa_pkg::status_e           out_status_q;

  // derived values
  logic [ffpa_pkg::CNT_W-1:0]  count;
  logic [ffpa_pkg::CNT_W-1:0]  from;
  logic [ffpa_pkg::IDX_W-1:0]  last_idx;
  logic [ffpa_pkg::ROW_W-1:0]  from_row, last_row, first_row;
  logic [ffpa_pkg::BASE_W:0]   free_diff;
  logic [ffpa_pkg::IDX_W-1:0]  free_idx;
  logic [ffpa_pkg::WORD_W-1:0] word;
  logic [ffpa_pkg::WORD_W-1:0] scan_mask, avail;
  logic [ffpa_pkg::BIT_W-1:0]  hit_bit;
  logic [ffpa_pkg::WORD_W-1:0] mark_mask;
  logic [ffpa_pkg::FILL_W-1:0] fill;
  logic [ffpa_pkg::WORD_W-1:0] init_mask;
  logic [ffpa_pkg::CNT_W-1:0]  run_v;
  logic                        run_found, run_stop;
  logic [ffpa_pkg::IDX_W-1:0]  step_idx, found_idx, run_start;
  logic                        rd_en, wr_en;
  logic [ffpa_pkg::ROW_W-1:0]  rd_row, wr_row;
  logic [ffpa_pkg::WORD_W-1:0] wr_data;
  logic [ffpa_pkg::BASE_W-1:0] frame_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      pages_q <= ffpa_pkg::PAGES_RST;
      floor_q <= ffpa_pkg::FLOOR_RST;
    end else if (cfg_valid_i) begin
      unique case (ffpa_pkg::cfg_idx_e'(cfg_index_i))
        ffpa_pkg::CFG_BASE_FRAME:   base_q  <= cfg_data_i[ffpa_pkg::BASE_W-1:0];
        ffpa_pkg::CFG_PAGES_IN_USE: pages_q <= cfg_data_i[ffpa_pkg::CNT_W-1:0];
        ffpa_pkg::CFG_USER_FLOOR:   floor_q <= cfg_data_i[ffpa_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q    <= ffpa_pkg::op_e'(in_cmd_i);
      len_q   <= in_run_length_i;
      frame_q <= in_phys_address_i[ffpa_pkg::ADDR_W-1:ffpa_pkg::PAGE_SHIFT];
    end
  end

  assign count = (pages_q > ffpa_pkg::CNT_W'(ffpa_pkg::MAX_PAGES)) ?
                 ffpa_pkg::CNT_W'(ffpa_pkg::MAX_PAGES) : pages_q;
  assign from  = (op_q == ffpa_pkg::OP_ALLOC_USER) ?
                 ((floor_q > count) ? count : floor_q) : '0;
  assign last_idx  = ffpa_pkg::IDX_W'(count - 1'b1);
  assign from_row  = from[ffpa_pkg::IDX_W-1:ffpa_pkg::BIT_W];
  assign last_row  = last_idx[ffpa_pkg::IDX_W-1:ffpa_pkg::BIT_W];
  assign free_diff = {1'b0, frame_q} - {1'b0, base_q};
  assign free_idx  = free_diff[ffpa_pkg::IDX_W-1:0];

  assign word = rvalid_q ? rdata_q : '0;

  // lowest free frame inside the allowed window of this row
  assign scan_mask = ffpa_pkg::range_mask(
      (eval_row_q == from_row) ? from[ffpa_pkg::BIT_W-1:0] : '0,
      (eval_row_q == last_row) ? last_idx[ffpa_pkg::BIT_W-1:0] : '1);
  assign avail = ~word & scan_mask;

  always_comb begin
    hit_bit = '0;
    for (int i = ffpa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (avail[i]) hit_bit = ffpa_pkg::BIT_W'(i);
    end
  end

  // run search over one chunk of the current row
  always_comb begin
    run_v     = run_q;
    run_found = 1'b0;
    run_stop  = 1'b0;
    found_idx = '0;
    step_idx  = '0;
    for (int k = 0; k < ffpa_pkg::CHUNK_W; k++) begin
      step_idx = {eval_row_q, chunk_q, ffpa_pkg::KSEL_W'(k)};
      if (!run_found && !run_stop) begin
        if ({1'b0, step_idx} >= count) begin
          run_stop = 1'b1;
        end else begin
          if (word[{chunk_q, ffpa_pkg::KSEL_W'(k)}]) begin
            run_v = '0;
          end else begin
            run_v = run_v + 1'b1;
            if (run_v == len_q) begin
              run_found = 1'b1;
              found_idx = step_idx;
            end
          end
          // stop at the last managed frame, also when the whole map is managed
          if (!run_found && step_idx == last_idx) run_stop = 1'b1;
        end
      end
    end
  end

  assign run_start = found_idx + 1'b1 - len_q[ffpa_pkg::IDX_W-1:0];

  assign mark_mask = ffpa_pkg::range_mask(
      (eval_row_q == hit_idx_q[ffpa_pkg::IDX_W-1:ffpa_pkg::BIT_W]) ?
        hit_idx_q[ffpa_pkg::BIT_W-1:0] : '0,
      (eval_row_q == end_idx_q[ffpa_pkg::IDX_W-1:ffpa_pkg::BIT_W]) ?
        end_idx_q[ffpa_pkg::BIT_W-1:0] : '1);

  // init row: frames below len occupied
  assign fill = {1'b0, len_q} - ffpa_pkg::FILL_W'({ptr_q, ffpa_pkg::BIT_W'(0)});
  always_comb begin
    if (fill[ffpa_pkg::FILL_W-1] || fill == '0) begin
      init_mask = '0;
    end else if (fill >= ffpa_pkg::FILL_W'(ffpa_pkg::WORD_W)) begin
      init_mask = '1;
    end else begin
      init_mask = ~({ffpa_pkg::WORD_W{1'b1}} << fill[ffpa_pkg::BIT_W-1:0]);
    end
  end

  always_comb begin
    unique case (op_q) inside
      ffpa_pkg::OP_ALLOC_ONE, ffpa_pkg::OP_ALLOC_USER: first_row = from_row;
      ffpa_pkg::OP_FREE: first_row = free_idx[ffpa_pkg::IDX_W-1:ffpa_pkg::BIT_W];
      default:           first_row = '0;
    endcase
  end

  assign rd_en  = cmd_i.rd_first | cmd_i.rd_next | cmd_i.mark_first;
  assign rd_row = cmd_i.rd_first   ? first_row :
                  cmd_i.mark_first ? hit_idx_q[ffpa_pkg::IDX_W-1:ffpa_pkg::BIT_W] :
                  ptr_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_row  = eval_row_q;
    wr_data = word;
    if (cmd_i.init_wr) begin
      wr_en   = 1'b1;
      wr_row  = ptr_q;
      wr_data = init_mask;
    end else if (cmd_i.scan_eval && (|avail)) begin
      wr_en   = 1'b1;
      wr_data = word | (ffpa_pkg::WORD_W'(1) << hit_bit);
    end else if (cmd_i.mark_eval) begin
      wr_en   = 1'b1;
      wr_data = word | mark_mask;
    end else if (cmd_i.free_wr) begin
      wr_en   = 1'b1;
      wr_data = word & ~(ffpa_pkg::WORD_W'(1) << free_idx[ffpa_pkg::BIT_W-1:0]);
    end
  end

  always_comb begin
    ptr_d      = ptr_q;
    eval_row_d = eval_row_q;
    if (cmd_i.load_in) begin
      ptr_d = '0;
    end else if (rd_en) begin
      ptr_d      = rd_row + 1'b1;
      eval_row_d = rd_row;
    end else if (cmd_i.init_wr) begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_row] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_row];
  end

  // a row never written since reset reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
      ptr_q       <= '0;
      eval_row_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) row_valid_q[wr_row] <= 1'b1;
      if (rd_en) rvalid_q <= row_valid_q[rd_row];
      ptr_q      <= ptr_d;
      eval_row_q <= eval_row_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_first) begin
      run_q   <= '0;
      chunk_q <= '0;
    end else if (cmd_i.run_eval) begin
      run_q   <= run_v;
      chunk_q <= chunk_q + 1'b1;
    end
    if (cmd_i.scan_eval && (|avail)) begin
      hit_idx_q <= {eval_row_q, hit_bit};
    end else if (cmd_i.run_eval && run_found) begin
      hit_idx_q <= run_start;
      end_idx_q <= found_idx;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_hit_q    <= cmd_i.res_hit;
    end
  end

  assign frame_sum = base_q + ffpa_pkg::BASE_W'(hit_idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_addr_q   <= res_hit_q ? {frame_sum, ffpa_pkg::PAGE_SHIFT'(0)} : '0;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_page_address_o = out_addr_q;
  assign out_status_o       = out_status_q;

  always_comb begin
    sts_o             = '0;
    sts_o.op          = op_q;
    sts_o.init_bad    = len_q > count;
    sts_o.alloc_empty = from >= count;
    sts_o.run_bad     = (len_q == '0) || (len_q > count);
    sts_o.free_bad    = free_diff[ffpa_pkg::BASE_W] ||
                        (free_diff[ffpa_pkg::BASE_W-1:0] >= ffpa_pkg::BASE_W'(count));
    sts_o.init_last   = ptr_q == '1;
    sts_o.scan_hit    = |avail;
    sts_o.scan_last   = eval_row_q == last_row;
    sts_o.run_found   = run_found;
    sts_o.run_stop    = run_stop;
    sts_o.chunk_last  = chunk_q == '1;
    sts_o.mark_last   = eval_row_q == end_idx_q[ffpa_pkg::IDX_W-1:ffpa_pkg::BIT_W];
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

// ===== sv/first_fit_page_frame_allocator_top.sv =====
// First-fit page frame allocator: a 16384-frame occupied map kept as 256
// rows of 64 bits. Request, result and configuration words each travel on
// a valid/ready channel; a word is taken when valid and ready are both high.
// Configuration writes (base_frame, pages_in_use, user_floor) are always
// ready; the user issues them only while no request is in flight, which
// the block does not enforce. One request is worked on at a time; ready
// on the request channel is high whenever the sequencer is idle, also
// while a result still waits. After dispatch, each command works so:
//   init: one row written per cycle over the whole map
//   alloc_one / alloc_user: one row scanned per cycle from the start row
//   alloc_run: chunks of 8 frames searched, then, when a run is found,
//              its first row read and the run marked one row at a time
//   free: one row read and rewritten; unused and rejected: no map access
// The result sits in an output register until taken; a stalled receiver
// holds the finished result and the sequencer waits before loading another.
// Reset clears the row valid flags, so the whole map reads as free at once,
// with no clearing pass; configuration returns to its reset values.
`default_nettype none

module first_fit_page_frame_allocator_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ffpa_in_if.sink    in_if,
  ffpa_out_if.source out_if,
  ffpa_cfg_if.sink   cfg_if
);

  ffpa_pkg::ctrl_cmd_t ctrl_cmd;
  ffpa_pkg::ctrl_sts_t ctrl_sts;
  logic                in_ready;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;

  ffpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  ffpa_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_cmd_i           (in_if.cmd),
    .in_run_length_i    (in_if.run_length),
    .in_phys_address_i  (in_if.phys_address),
    .cfg_valid_i        (cfg_if.valid),
    .cfg_index_i        (cfg_if.index),
    .cfg_data_i         (cfg_if.data),
    .cmd_i              (ctrl_cmd),
    .sts_o              (ctrl_sts),
    .out_valid_o        (out_if.valid),
    .out_ready_i        (out_if.ready),
    .out_page_address_o (out_if.page_address),
    .out_status_o       (out_if.status)
  );

endmodule

`default_nettype wire

// ===== test/tb_first_fit_page_frame_allocator_top.sv =====
`timescale 1ns / 1ps
// Testbench for first_fit_page_frame_allocator_top: directed and random request
// streams, each result word checked against an in-bench bitmap predictor.
// Depends on ffpa_pkg, the ffpa_if channel interfaces and the allocator RTL.

module tb_first_fit_page_frame_allocator_top;

  localparam int unsigned PHASES        = 11;
  localparam int unsigned PHASE_ITEMS   = 105;
  localparam int unsigned SETTLE_CYCLES = 2400;

  typedef struct packed {
    logic [ffpa_pkg::ADDR_W-1:0]   page_address;
    logic [ffpa_pkg::STATUS_W-1:0] status;
  } page_result_t;

  logic clk_i;
  logic rst_ni;

  ffpa_in_if  req_ch ();
  ffpa_out_if res_ch ();
  ffpa_cfg_if cfg_ch ();

  first_fit_page_frame_allocator_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_ch),
    .out_if (res_ch),
    .cfg_if (cfg_ch)
  );

  // predictor state and configuration copy
  logic [ffpa_pkg::MAX_PAGES-1:0] frame_busy;
  logic [ffpa_pkg::BASE_W-1:0]    base_frame_q;
  logic [ffpa_pkg::CNT_W-1:0]     page_count_q;
  logic [ffpa_pkg::CNT_W-1:0]     user_floor_q;

  page_result_t                expected_results[$];
  logic [ffpa_pkg::ADDR_W-1:0] held_pages[$];
  int unsigned                 err_count;
  bit                          quiet;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned managed_frames();
    int unsigned n;
    n = page_count_q;
    return (n > ffpa_pkg::MAX_PAGES) ? ffpa_pkg::MAX_PAGES : n;
  endfunction

  function automatic logic [ffpa_pkg::ADDR_W-1:0] frame_to_address(
      input int unsigned idx);
    logic [63:0] frame;
    frame = 64'(base_frame_q) + 64'(idx);
    return ffpa_pkg::ADDR_W'(frame << ffpa_pkg::PAGE_SHIFT);
  endfunction

  function automatic logic [ffpa_pkg::ADDR_W-1:0] random_address();
    return ffpa_pkg::ADDR_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [ffpa_pkg::BASE_W-1:0] random_base();
    return ffpa_pkg::BASE_W'({$urandom(), $urandom()});
  endfunction

  // Apply one request to the bitmap copy and return the result word it gives.
  function automatic page_result_t predict_page_result(
      input logic [ffpa_pkg::CMD_W-1:0]  cmd,
      input logic [ffpa_pkg::CNT_W-1:0]  len,
      input logic [ffpa_pkg::ADDR_W-1:0] addr);
    page_result_t res;
    int unsigned  cnt;
    int unsigned  from;
    int unsigned  idx;
    int unsigned  run;
    int unsigned  start;
    logic [63:0]  frame;
    bit           found;
    res.page_address = '0;
    res.status       = ffpa_pkg::ST_OK;
    cnt              = managed_frames();
    case (cmd)
      ffpa_pkg::OP_INIT: begin
        if (len > cnt) begin
          res.status = ffpa_pkg::ST_BAD;
        end else begin
          frame_busy = '0;
          for (idx = 0; idx < len; idx++) frame_busy[idx] = 1'b1;
        end
      end
      ffpa_pkg::OP_ALLOC_ONE, ffpa_pkg::OP_ALLOC_USER: begin
        from = 0;
        if (cmd == ffpa_pkg::OP_ALLOC_USER) begin
          from = (user_floor_q > cnt) ? cnt : user_floor_q;
        end
        idx = from;
        while (idx < cnt && frame_busy[idx]) idx++;
        if (idx >= cnt) begin
          res.status = ffpa_pkg::ST_NONE;
        end else begin
          frame_busy[idx]  = 1'b1;
          res.page_address = frame_to_address(idx);
          held_pages.push_back(res.page_address);
        end
      end
      ffpa_pkg::OP_ALLOC_RUN: begin
        found = 1'b0;
        run   = 0;
        start = 0;
        if (len != 0 && len <= cnt) begin
          for (idx = 0; idx < cnt && !found; idx++) begin
            if (frame_busy[idx]) begin
              run = 0;
            end else begin
              run++;
              if (run == len) begin
                start = idx + 1 - len;
                found = 1'b1;
              end
            end
          end
        end
        if (!found) begin
          res.status = ffpa_pkg::ST_NONE;
        end else begin
          for (idx = start; idx < start + len; idx++) begin
            frame_busy[idx] = 1'b1;
            held_pages.push_back(frame_to_address(idx));
          end
          res.page_address = frame_to_address(start);
        end
      end
      ffpa_pkg::OP_FREE: begin
        frame = 64'(addr >> ffpa_pkg::PAGE_SHIFT);
        if (frame < 64'(base_frame_q) || frame - 64'(base_frame_q) >= 64'(cnt)) begin
          res.status = ffpa_pkg::ST_BAD;
        end else begin
          frame_busy[frame - 64'(base_frame_q)] = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Leave valid high on return so back-to-back words follow without valid dropping.
  task automatic send_request(input logic [ffpa_pkg::CMD_W-1:0]  cmd,
                              input logic [ffpa_pkg::CNT_W-1:0]  len,
                              input logic [ffpa_pkg::ADDR_W-1:0] addr);
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= cmd;
    req_ch.run_length   <= len;
    req_ch.phys_address <= addr;
    do @(posedge clk_i); while (!req_ch.ready);
    expected_results.push_back(predict_page_result(cmd, len, addr));
  endtask

  task automatic sender_pause();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic drain_requests();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input ffpa_pkg::cfg_idx_e idx,
                                input logic [ffpa_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      ffpa_pkg::CFG_BASE_FRAME:   base_frame_q = value[ffpa_pkg::BASE_W-1:0];
      ffpa_pkg::CFG_PAGES_IN_USE: page_count_q = value[ffpa_pkg::CNT_W-1:0];
      ffpa_pkg::CFG_USER_FLOOR:   user_floor_q = value[ffpa_pkg::CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Write all three registers once the allocator has gone idle.
  task automatic apply_settings(input logic [ffpa_pkg::BASE_W-1:0] base,
                                input int unsigned pages,
                                input int unsigned floor_idx);
    drain_requests();
    write_register(ffpa_pkg::CFG_BASE_FRAME, ffpa_pkg::CFG_DATA_W'(base));
    write_register(ffpa_pkg::CFG_PAGES_IN_USE,
                   ffpa_pkg::CFG_DATA_W'(ffpa_pkg::CNT_W'(pages)));
    write_register(ffpa_pkg::CFG_USER_FLOOR,
                   ffpa_pkg::CFG_DATA_W'(ffpa_pkg::CNT_W'(floor_idx)));
    cfg_ch.valid <= 1'b0;
    held_pages.delete();
  endtask

  task automatic test_default_settings();
    send_request(ffpa_pkg::OP_ALLOC_ONE, '0, '0);
    send_request(ffpa_pkg::OP_ALLOC_USER, '0, '0);
    send_request(ffpa_pkg::OP_ALLOC_RUN, 15'd3, '0);
    send_request(ffpa_pkg::OP_FREE, '0, ffpa_pkg::ADDR_W'(52'h2000));
    // double free is accepted
    send_request(ffpa_pkg::OP_FREE, '0, ffpa_pkg::ADDR_W'(52'h2000));
    send_request(ffpa_pkg::OP_FREE, '0, '1);
    send_request(ffpa_pkg::OP_FREE, '0,
                 ffpa_pkg::ADDR_W'(64'(ffpa_pkg::MAX_PAGES) << ffpa_pkg::PAGE_SHIFT));
    send_request(ffpa_pkg::OP_ALLOC_RUN, '0, '0);
    send_request(ffpa_pkg::OP_ALLOC_RUN, '1, '0);
    send_request(ffpa_pkg::OP_INIT, '1, '0);
    send_request(ffpa_pkg::OP_INIT, ffpa_pkg::CNT_W'(ffpa_pkg::MAX_PAGES), '0);
    send_request(ffpa_pkg::OP_ALLOC_ONE, '0, '0);
    send_request(ffpa_pkg::OP_ALLOC_USER, '0, '0);
    send_request(ffpa_pkg::CMD_W'(5), '1, '1);
    send_request(ffpa_pkg::CMD_W'(7), '0, '0);
    send_request(ffpa_pkg::OP_INIT, 15'd1, '0);
  endtask

  task automatic test_setting_extremes();
    // top base frame: addresses wrap past 52 bits
    apply_settings('1, 64, 0);
    send_request(ffpa_pkg::OP_ALLOC_USER, '0, '0);
    send_request(ffpa_pkg::OP_ALLOC_RUN, 15'd64, '0);
    send_request(ffpa_pkg::OP_ALLOC_RUN, 15'd62, '0);
    send_request(ffpa_pkg::OP_FREE, '0, ffpa_pkg::ADDR_W'({base_frame_q, 12'hfff}));
    send_request(ffpa_pkg::OP_FREE, '0, frame_to_address(63));
    // no managed frames, floor beyond the count
    apply_settings('1, 0, ffpa_pkg::MAX_PAGES);
    send_request(ffpa_pkg::OP_ALLOC_ONE, '0, '0);
    send_request(ffpa_pkg::OP_INIT, '0, '0);
    send_request(ffpa_pkg::OP_INIT, 15'd1, '0);
    send_request(ffpa_pkg::OP_FREE, '0, ffpa_pkg::ADDR_W'({base_frame_q, 12'h000}));
    // count saturates at the map depth
    apply_settings('0, 32767, ffpa_pkg::MAX_PAGES);
    send_request(ffpa_pkg::OP_ALLOC_USER, '0, '0);
    send_request(ffpa_pkg::OP_ALLOC_ONE, '0, '0);
  endtask

  task automatic send_random_request();
    int unsigned                 cnt;
    int unsigned                 pick;
    int unsigned                 slot;
    logic [ffpa_pkg::CNT_W-1:0]  len;
    logic [ffpa_pkg::ADDR_W-1:0] addr;
    logic [63:0]                 frame;
    cnt  = managed_frames();
    len  = ffpa_pkg::CNT_W'($urandom());
    addr = random_address();
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_request(ffpa_pkg::OP_ALLOC_ONE, len, addr);
    end else if (pick < 40) begin
      send_request(ffpa_pkg::OP_ALLOC_USER, len, addr);
    end else if (pick < 60) begin
      if ($urandom_range(0, 7) == 0) len = ffpa_pkg::CNT_W'($urandom_range(1, cnt));
      else len = ffpa_pkg::CNT_W'($urandom_range(1, (cnt < 16) ? cnt : 16));
      send_request(ffpa_pkg::OP_ALLOC_RUN, len, addr);
    end else if (pick < 85) begin
      if (held_pages.size() != 0 && $urandom_range(0, 4) != 0) begin
        slot = $urandom_range(0, held_pages.size() - 1);
        addr = held_pages[slot] | ffpa_pkg::ADDR_W'($urandom_range(0, 4095));
        held_pages.delete(slot);
      end else if ($urandom_range(0, 1) == 0) begin
        // hover around both ends of the managed window
        frame = 64'(base_frame_q) + 64'($urandom_range(0, cnt + 3)) - 64'd2;
        addr  = ffpa_pkg::ADDR_W'(frame << ffpa_pkg::PAGE_SHIFT) |
                ffpa_pkg::ADDR_W'($urandom_range(0, 4095));
      end
      send_request(ffpa_pkg::OP_FREE, len, addr);
    end else if (pick < 90) begin
      if ($urandom_range(0, 3) != 0) len = ffpa_pkg::CNT_W'($urandom_range(0, cnt));
      send_request(ffpa_pkg::OP_INIT, len, addr);
      held_pages.delete();
    end else if (pick < 95) begin
      send_request(ffpa_pkg::OP_ALLOC_RUN, len, addr);
    end else begin
      send_request(ffpa_pkg::CMD_W'($urandom_range(5, 7)), len, addr);
    end
  endtask

  task automatic test_random_phases();
    int unsigned                 pages;
    int unsigned                 floor_idx;
    logic [ffpa_pkg::BASE_W-1:0] base;
    for (int p = 0; p < PHASES; p++) begin
      base      = ($urandom_range(0, 2) == 0) ? '0 : random_base();
      pages     = $urandom_range(2, 600);
      floor_idx = $urandom_range(0, pages + 8);
      if (p == 0) begin
        pages     = 1;
        floor_idx = 0;
      end
      if (p == 3) begin
        pages     = ffpa_pkg::MAX_PAGES;
        floor_idx = $urandom_range(0, ffpa_pkg::MAX_PAGES);
      end
      if (p == 5) floor_idx = $urandom_range(0, 32767);
      if (p == 7) begin
        pages = 32767;
        base  = '1;
      end
      apply_settings(base, pages, floor_idx);
      quiet = (p == PHASES - 1);
      send_request(ffpa_pkg::OP_INIT,
                   ffpa_pkg::CNT_W'($urandom_range(0, managed_frames() / 2)),
                   random_address());
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        sender_pause();
        send_random_request();
      end
    end
  endtask

  initial begin : result_ready_driver
    forever begin
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!quiet) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    page_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        err_count++;
        $display("%0t: result word with none pending: expected nothing, actual %h/%0d",
                 $time, res_ch.page_address, res_ch.status);
      end else begin
        want = expected_results.pop_front();
        if (res_ch.page_address !== want.page_address) begin
          err_count++;
          $display("%0t: page_address mismatch: expected %h, actual %h",
                   $time, want.page_address, res_ch.page_address);
        end
        if (res_ch.status !== want.status) begin
          err_count++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, res_ch.status);
        end
      end
    end
  end

  initial begin
    rst_ni              <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.cmd          <= '0;
    req_ch.run_length   <= '0;
    req_ch.phys_address <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= ffpa_pkg::CFG_BASE_FRAME;
    cfg_ch.data         <= '0;
    frame_busy   = '0;
    base_frame_q = '0;
    page_count_q = ffpa_pkg::PAGES_RST;
    user_floor_q = ffpa_pkg::FLOOR_RST;
    err_count    = 0;
    quiet        = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_settings();
    test_setting_extremes();
    test_random_phases();
    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
